// ===== src/bblur_pkg.sv =====
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared constants for the box blur block: field widths, register indexes,
// operation codes and parameter defaults.
// ----------------------------------------------------------------------------
package bblur_pkg;

  // Payload widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // Parameter defaults
  localparam int WINDOW_DEF      = 15;
  localparam int MAX_COLUMNS_DEF = 1024;

  // Row count saturates here; column count resets to this (clipped to MAX_COLUMNS)
  localparam int ROW_LIMIT   = 1024;
  localparam int COLS_RESET  = 1024;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS    = 2'd1;

  // Input operation codes
  localparam logic OP_PIXEL = 1'b0;

endpackage

// ===== src/bblur_if.sv =====
// ----------------------------------------------------------------------------
// bblur channel interfaces
// Valid/ready channels for pixels in, blurred results out and register writes.
// ----------------------------------------------------------------------------

// Pixel input channel
interface bblur_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [bblur_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output operation, output pixel, input ready);
  modport sink   (input valid, input operation, input pixel, output ready);
endinterface

// Result channel
interface bblur_out_if;
  logic                       valid;
  logic                       ready;
  logic [bblur_pkg::PIX_W-1:0] blurred;
  logic                       last;

  modport source (output valid, output blurred, output last, input ready);
  modport sink   (input valid, input blurred, input last, output ready);
endinterface

// Register write channel
interface bblur_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bblur_pkg::CFG_IDX_W-1:0] index;
  logic [bblur_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/bblur_ram.sv =====
// ----------------------------------------------------------------------------
// bblur_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module bblur_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bblur_div.sv =====
// ----------------------------------------------------------------------------
// bblur_div
// Divides the window sum by WINDOW*WINDOW with a reciprocal multiply.
// One register stage; the quotient is a bit slice of the product.
// ----------------------------------------------------------------------------
module bblur_div #(
  parameter  int WINDOW = bblur_pkg::WINDOW_DEF,
  localparam int PIX_MAX = (1 << bblur_pkg::PIX_W) - 1,
  localparam int DIVISOR = WINDOW * WINDOW,
  localparam int SUM_W   = $clog2(DIVISOR * PIX_MAX + 1)
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [SUM_W-1:0]            sum,
  output logic [bblur_pkg::PIX_W-1:0] quot
);

  // With SHIFT = SUM_W + clog2(DIVISOR) the rounded-up reciprocal is exact
  // for every sum below 2**SUM_W.
  localparam int          SHIFT  = SUM_W + $clog2(DIVISOR);
  localparam longint      RECIP  = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int          REC_W  = $clog2(RECIP + 1);
  localparam int          PROD_W = SUM_W + REC_W;

  logic [REC_W-1:0]  recip;
  logic [PROD_W-1:0] prod_r;

  assign recip = REC_W'(RECIP);

  // Product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(sum) * PROD_W'(recip);
    end
  end

  assign quot = prod_r[SHIFT +: bblur_pkg::PIX_W];

endmodule

// ===== src/box_blur_15x15_top.sv =====
// ----------------------------------------------------------------------------
// box_blur_15x15_top
// WINDOW x WINDOW mean blur over a raster-order grayscale stream, zero padded.
// ----------------------------------------------------------------------------
// The host sends (rows+H) x (columns+H) items, H = (WINDOW-1)/2, in raster
// order; items past the right or bottom edge of the image (or marked as drain)
// add zero. The result for pixel (r,c) leaves with the item at (r+H,c+H), and
// the final pixel carries last. One item is taken every clock while no stall
// reaches the input; results come from a five-stage pipeline with bubble
// collapsing, so input keeps flowing while a result waits until the pipeline fills.
// Throughput is set by the line store (WINDOW*MAX_COLUMNS bytes, one read-first
// port pair) and the column-sum RAM (MAX_COLUMNS words), each touched once per
// item. No clearing pass is needed after reset: position masking keeps stale
// entries out. Writing either register restarts the frame at position (0,0);
// write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module box_blur_15x15_top #(
  parameter int WINDOW      = bblur_pkg::WINDOW_DEF,
  parameter int MAX_COLUMNS = bblur_pkg::MAX_COLUMNS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  bblur_in_if.sink    in_chan,
  bblur_out_if.source out_chan,
  bblur_cfg_if.sink   cfg_chan
);

  localparam int PIX_W    = bblur_pkg::PIX_W;
  localparam int PIX_MAX  = (1 << PIX_W) - 1;
  localparam int HALF     = (WINDOW - 1) / 2;
  localparam int COL_W    = $clog2(WINDOW * PIX_MAX + 1);
  localparam int SUM_W    = $clog2(WINDOW * WINDOW * PIX_MAX + 1);
  localparam int SUM_MAX  = WINDOW * WINDOW * PIX_MAX;
  localparam int VC_W     = $clog2(MAX_COLUMNS + HALF);
  localparam int VR_W     = $clog2(bblur_pkg::ROW_LIMIT + HALF);
  localparam int CI_W     = $clog2(MAX_COLUMNS);
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int LS_DEPTH = WINDOW * MAX_COLUMNS;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int COLS_RST = (bblur_pkg::COLS_RESET > MAX_COLUMNS) ? MAX_COLUMNS
                                                                   : bblur_pkg::COLS_RESET;

  // Per-item control that rides along the pipeline
  typedef struct packed {
    logic first;   // first column of a grid row
    logic drop;    // a column leaves the window
    logic emit;    // item produces a result
    logic last;    // result for the final pixel
  } item_ctl_t;

  // --------------------------------------------------------------------------
  // Handshake chain (bubble collapsing)
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic out_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic in_acc;

  assign out_rdy = !out_v_r || out_chan.ready;
  assign s4_rdy  = !s4_v_r  || out_rdy;
  assign s3_rdy  = !s3_v_r  || s4_rdy;
  assign s2_rdy  = !s2_v_r  || s3_rdy;
  assign s1_rdy  = !s1_v_r  || s2_rdy;

  assign in_chan.ready = s1_rdy;
  assign in_acc        = in_chan.valid && s1_rdy;

  // --------------------------------------------------------------------------
  // Configuration and grid position
  // --------------------------------------------------------------------------
  logic [VC_W-1:0]   cols_r, cols_nxt;
  logic [VR_W-1:0]   rows_r, rows_nxt;
  logic [VC_W-1:0]   vc_r, vc_nxt;
  logic [VR_W-1:0]   vr_r, vr_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              cfg_hit;
  int unsigned       cfg_val;

  assign cfg_chan.ready = 1'b1;

  // Saturate register values into their legal ranges
  always_comb begin
    cfg_val  = 32'(cfg_chan.data);
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    cfg_hit  = 1'b0;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        bblur_pkg::REG_IMAGE_COLUMNS: begin
          cfg_hit = 1'b1;
          if (cfg_val == 0) cols_nxt = VC_W'(1);
          else if (cfg_val > MAX_COLUMNS) cols_nxt = VC_W'(MAX_COLUMNS);
          else cols_nxt = VC_W'(cfg_val);
        end
        bblur_pkg::REG_IMAGE_ROWS: begin
          cfg_hit = 1'b1;
          if (cfg_val == 0) rows_nxt = VR_W'(1);
          else if (cfg_val > bblur_pkg::ROW_LIMIT) rows_nxt = VR_W'(bblur_pkg::ROW_LIMIT);
          else rows_nxt = VR_W'(cfg_val);
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  logic in_col, in_img, col_end, row_end;
  logic [PIX_W-1:0] pix_v;
  logic [LS_AW-1:0] ls_addr;

  assign in_col  = vc_r < cols_r;
  assign in_img  = in_col && (vr_r < rows_r);
  assign col_end = 32'(vc_r) == 32'(cols_r) + HALF - 1;
  assign row_end = 32'(vr_r) == 32'(rows_r) + HALF - 1;
  assign pix_v   = (in_chan.operation == bblur_pkg::OP_PIXEL && in_img) ? in_chan.pixel : '0;
  assign ls_addr = LS_AW'(32'(slot_r) * MAX_COLUMNS) + LS_AW'(vc_r[CI_W-1:0]);

  // Raster walk over the virtual grid; slot tracks row modulo WINDOW
  always_comb begin
    vc_nxt   = vc_r;
    vr_nxt   = vr_r;
    slot_nxt = slot_r;
    if (cfg_hit) begin
      vc_nxt   = '0;
      vr_nxt   = '0;
      slot_nxt = '0;
    end else if (in_acc) begin
      if (col_end) begin
        vc_nxt = '0;
        if (row_end) begin
          vr_nxt   = '0;
          slot_nxt = '0;
        end else begin
          vr_nxt   = vr_r + VR_W'(1);
          slot_nxt = (32'(slot_r) == WINDOW - 1) ? '0 : slot_r + SLOT_W'(1);
        end
      end else begin
        vc_nxt = vc_r + VC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= VC_W'(COLS_RST);
      rows_r <= VR_W'(bblur_pkg::ROW_LIMIT);
      vc_r   <= '0;
      vr_r   <= '0;
      slot_r <= '0;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
      vc_r   <= vc_nxt;
      vr_r   <= vr_nxt;
      slot_r <= slot_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line store and column-sum reads in flight
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_in_col_r, s1_row0_r, s1_sub_r;
  logic [CI_W-1:0]  s1_col_idx_r;
  item_ctl_t        s1_ctl_r, s0_ctl;
  logic [PIX_W-1:0] line_rd;
  logic [COL_W-1:0] col_rd;

  assign s0_ctl.first = (vc_r == '0);
  assign s0_ctl.drop  = 32'(vc_r) >= WINDOW;
  assign s0_ctl.emit  = (32'(vr_r) >= HALF) && (32'(vc_r) >= HALF);
  assign s0_ctl.last  = row_end && col_end;

  // Line store: write the new value where row r-WINDOW is read out
  bblur_ram #(
    .WIDTH (PIX_W),
    .DEPTH (LS_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (in_acc && in_col),
    .waddr (ls_addr),
    .wdata (pix_v),
    .re    (in_acc),
    .raddr (ls_addr),
    .rdata (line_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r     <= pix_v;
      s1_in_col_r  <= in_col;
      s1_row0_r    <= (vr_r == '0);
      s1_sub_r     <= 32'(vr_r) >= WINDOW;
      s1_col_idx_r <= vc_r[CI_W-1:0];
      s1_ctl_r     <= s0_ctl;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: running column sum, written back to the column-sum RAM
  // --------------------------------------------------------------------------
  logic [COL_W:0]   col_acc;
  logic [COL_W-1:0] col_new;
  logic [COL_W-1:0] s2_col_r;
  item_ctl_t        s2_ctl_r;
  logic             col_we;

  assign col_acc = (COL_W+1)'(s1_row0_r ? '0 : col_rd) + (COL_W+1)'(s1_pix_r)
                 - (COL_W+1)'(s1_sub_r ? line_rd : '0);
  assign col_new = s1_in_col_r ? col_acc[COL_W-1:0] : '0;
  assign col_we  = s1_v_r && s2_rdy && s1_in_col_r;

  bblur_ram #(
    .WIDTH (COL_W),
    .DEPTH (MAX_COLUMNS)
  ) u_col_sums (
    .clk   (clk),
    .we    (col_we),
    .waddr (s1_col_idx_r),
    .wdata (col_new),
    .re    (in_acc),
    .raddr (vc_r[CI_W-1:0]),
    .rdata (col_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_rdy) begin
      s2_col_r <= col_new;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: running window sum over the last WINDOW column sums
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] taps_r [WINDOW];
  logic [SUM_W:0]   ws_acc;
  logic [SUM_W-1:0] ws_r, ws_nxt;
  logic             s3_last_r;
  logic             s2_go;

  assign s2_go  = s2_v_r && s3_rdy;
  assign ws_acc = (SUM_W+1)'(s2_ctl_r.first ? '0 : ws_r) + (SUM_W+1)'(s2_col_r)
                - (SUM_W+1)'(s2_ctl_r.drop ? taps_r[WINDOW-1] : '0);
  assign ws_nxt = ws_acc[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (s2_go) begin
      ws_r      <= ws_nxt;
      s3_last_r <= s2_ctl_r.last;
      taps_r[0] <= s2_col_r;
      for (int i = 1; i < WINDOW; i++) begin
        taps_r[i] <= taps_r[i-1];
      end
    end
  end

  // Only items that produce a result go on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r && s2_ctl_r.emit;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: divide by WINDOW*WINDOW
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] quot;
  logic             s4_last_r;

  bblur_div #(
    .WINDOW (WINDOW)
  ) u_div (
    .clk  (clk),
    .en   (s3_v_r && s4_rdy),
    .sum  (ws_r),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && s4_rdy) begin
      s4_last_r <= s3_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] blurred_r;
  logic             last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_v_r && out_rdy) begin
      blurred_r <= quot;
      last_r    <= s4_last_r;
    end
  end

  assign out_chan.valid   = out_v_r;
  assign out_chan.blurred = blurred_r;
  assign out_chan.last    = last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(vc_r) < 32'(cols_r) + HALF) && (32'(vr_r) < 32'(rows_r) + HALF))
    else $error("grid position outside the virtual grid");

  a_slot_row0: assert property (@(posedge clk) disable iff (!rst_n)
    (vr_r == '0) |-> (slot_r == '0))
    else $error("line store slot out of step with row");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_chan.valid && (cfg_chan.index == bblur_pkg::REG_IMAGE_COLUMNS ||
                        cfg_chan.index == bblur_pkg::REG_IMAGE_ROWS))
    |=> (vc_r == '0) && (vr_r == '0) && (slot_r == '0))
    else $error("register write did not restart the frame");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (32'(ws_r) <= SUM_MAX))
    else $error("window sum above its maximum");

endmodule
